### hdl/psd_pkg.sv
// ---------------------------------------------------------------------------
// psd_pkg: shared types for the point-to-segment distance block
// Item structs, nearest-part codes and the per-stage control group.
// ---------------------------------------------------------------------------
package psd_pkg;

  localparam int DIST_W = 49;

  typedef enum logic [1:0] {
    PART_DEGEN    = 2'd0,
    PART_START    = 2'd1,
    PART_END      = 2'd2,
    PART_INTERIOR = 2'd3
  } part_t;

  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } psd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        nearest_part;
  } psd_out_t;

  typedef struct packed {
    logic  vld;
    part_t part;
  } ctl_t;

endpackage

### hdl/psd_front.sv
// ---------------------------------------------------------------------------
// psd_front: vector front end
// Differences, products, case decision and the scaled radicand / divisor
// handed to the root cell chain.
// ---------------------------------------------------------------------------
module psd_front #(
  parameter int CW   = 32,
  parameter int FRAC = 16,
  parameter int SW   = 2 * (CW + 1) + 1,
  parameter int RW   = 2 * SW + 2 * FRAC + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  psd_pkg::psd_in_t  in_data,
  output psd_pkg::ctl_t     out_ctl,
  output logic [RW-1:0]     out_m,
  output logic [SW-1:0]     out_den
);
  import psd_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int H  = (SW + 1) / 2;

  // stage 1: coordinates
  logic              v1_r;
  logic [CW-1:0]     sx_r, sy_r, ex_r, ey_r, px_r, py_r;
  // stage 2: differences
  logic              v2_r;
  logic signed [DW-1:0] dx_r, dy_r, qx_r, qy_r, rx_r, ry_r;
  // stage 3: products
  logic              v3_r;
  logic signed [PW-1:0] dxdx_r, dydy_r, dxqx_r, dyqy_r, dxqy_r, dyqx_r;
  logic signed [PW-1:0] qxqx_r, qyqy_r, rxrx_r, ryry_r;
  // stage 4: sums
  logic              v4_r;
  logic signed [SW-1:0] l2_r, dot_r, crs_r, nq_r, nr_r;
  // stage 5: case and partial squares
  ctl_t              c5_r;
  logic [SW-1:0]     n5_r, den5_r;
  logic [2*H-1:0]    pll_r, plh_r, phh_r;
  // stage 6
  ctl_t              c6_r;
  logic [RW-1:0]     m6_r;
  logic [SW-1:0]     den6_r;

  function automatic logic signed [DW-1:0] sub(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
    sub = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
  endfunction

  logic signed [SW:0] over;
  logic [SW-1:0]      acrs;
  logic [2*H-1:0]     xc;
  ctl_t               c5_nxt;
  logic [SW-1:0]      n5_nxt, den5_nxt;
  logic [RW-1:0]      sq, m6_nxt;

  always_comb begin
    over = (SW + 1)'(l2_r) - (SW + 1)'(dot_r);
    acrs = crs_r[SW-1] ? SW'(-crs_r) : SW'(crs_r);
    xc   = (2 * H)'(acrs);
    c5_nxt.vld = v4_r;
    n5_nxt     = SW'(nq_r);
    den5_nxt   = SW'(1);
    if (l2_r == '0) begin
      c5_nxt.part = PART_DEGEN;
    end else if (dot_r[SW-1]) begin
      c5_nxt.part = PART_START;
    end else if (over[SW]) begin
      c5_nxt.part = PART_END;
      n5_nxt      = SW'(nr_r);
    end else begin
      c5_nxt.part = PART_INTERIOR;
      den5_nxt    = SW'(l2_r);
    end
  end

  always_comb begin
    sq = (RW'(phh_r) << (2 * H)) + (RW'(plh_r) << (H + 1)) + RW'(pll_r);
    if (c5_r.part == PART_INTERIOR) begin
      m6_nxt = sq << (2 * FRAC);
    end else begin
      m6_nxt = RW'(n5_r) << (2 * FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      c5_r   <= '0;
      c6_r   <= '0;
    end else if (en) begin
      v1_r   <= in_vld;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      c5_r   <= c5_nxt;
      c6_r   <= c5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= in_data.seg_start_x[CW-1:0];
      sy_r <= in_data.seg_start_y[CW-1:0];
      ex_r <= in_data.seg_end_x[CW-1:0];
      ey_r <= in_data.seg_end_y[CW-1:0];
      px_r <= in_data.point_x[CW-1:0];
      py_r <= in_data.point_y[CW-1:0];
      dx_r <= sub(ex_r, sx_r);
      dy_r <= sub(ey_r, sy_r);
      qx_r <= sub(px_r, sx_r);
      qy_r <= sub(py_r, sy_r);
      rx_r <= sub(px_r, ex_r);
      ry_r <= sub(py_r, ey_r);
      dxdx_r <= dx_r * dx_r;
      dydy_r <= dy_r * dy_r;
      dxqx_r <= dx_r * qx_r;
      dyqy_r <= dy_r * qy_r;
      dxqy_r <= dx_r * qy_r;
      dyqx_r <= dy_r * qx_r;
      qxqx_r <= qx_r * qx_r;
      qyqy_r <= qy_r * qy_r;
      rxrx_r <= rx_r * rx_r;
      ryry_r <= ry_r * ry_r;
      l2_r  <= SW'(dxdx_r) + SW'(dydy_r);
      dot_r <= SW'(dxqx_r) + SW'(dyqy_r);
      crs_r <= SW'(dxqy_r) - SW'(dyqx_r);
      nq_r  <= SW'(qxqx_r) + SW'(qyqy_r);
      nr_r  <= SW'(rxrx_r) + SW'(ryry_r);
      n5_r   <= n5_nxt;
      den5_r <= den5_nxt;
      pll_r  <= xc[H-1:0] * xc[H-1:0];
      plh_r  <= xc[H-1:0] * xc[2*H-1:H];
      phh_r  <= xc[2*H-1:H] * xc[2*H-1:H];
      m6_r   <= m6_nxt;
      den6_r <= den5_r;
    end
  end

  assign out_ctl = c6_r;
  assign out_m   = m6_r;
  assign out_den = den6_r;

endmodule

### hdl/psd_root_cell.sv
// ---------------------------------------------------------------------------
// psd_root_cell: one bit of the scaled quotient root
// Tries bit BIT of q against q^2*den <= m, keeping the remainder and q*den.
// ---------------------------------------------------------------------------
module psd_root_cell #(
  parameter int BIT = 0,
  parameter int SW  = 67,
  parameter int RW  = 184
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  psd_pkg::ctl_t              in_ctl,
  input  logic [RW-1:0]              in_rem,
  input  logic [psd_pkg::DIST_W+SW-1:0] in_acc,
  input  logic [SW-1:0]              in_den,
  input  logic [psd_pkg::DIST_W-1:0] in_q,
  output psd_pkg::ctl_t              out_ctl,
  output logic [RW-1:0]              out_rem,
  output logic [psd_pkg::DIST_W+SW-1:0] out_acc,
  output logic [SW-1:0]              out_den,
  output logic [psd_pkg::DIST_W-1:0] out_q
);
  import psd_pkg::*;

  localparam int AW = DIST_W + SW;

  ctl_t            ctl_r;
  logic [RW-1:0]   rem_r, inc;
  logic [AW-1:0]   acc_r;
  logic [SW-1:0]   den_r;
  logic [DIST_W-1:0] q_r;
  logic            take;

  assign inc  = (RW'(in_acc) << (BIT + 1)) + (RW'(in_den) << (2 * BIT));
  assign take = inc <= in_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= in_den;
      if (take) begin
        rem_r <= in_rem - inc;
        acc_r <= in_acc + (AW'(in_den) << BIT);
        q_r   <= in_q | (DIST_W'(1) << BIT);
      end else begin
        rem_r <= in_rem;
        acc_r <= in_acc;
        q_r   <= in_q;
      end
    end
  end

  assign out_ctl = ctl_r;
  assign out_rem = rem_r;
  assign out_acc = acc_r;
  assign out_den = den_r;
  assign out_q   = q_r;

endmodule

### hdl/point_segment_distance.sv
// Pipeline: six front stages, then one root cell per distance bit.
// Throughput: one item per cycle; the whole pipeline holds while a
// result is stalled at the output.
// Reset: synchronous, active low; clears all stage valid flags.
// ---------------------------------------------------------------------------
// point_segment_distance: distance from a point to a closed 2-D segment
// Front end computes the case and radicand, a chain of root cells
// resolves the fixed-point distance one bit per cell.
// ---------------------------------------------------------------------------
module point_segment_distance #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psd_pkg::psd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psd_pkg::psd_out_t out_data
);
  import psd_pkg::*;

  localparam int SW  = 2 * (COORD_WIDTH + 1) + 1;
  localparam int RA  = 2 * SW + 2 * FRAC_BITS;
  localparam int RB  = 2 * DIST_W + SW + 1;
  localparam int RW  = ((RA > RB) ? RA : RB) + 2;
  localparam int AW  = DIST_W + SW;
  localparam int N   = DIST_W;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ctl_t              ctl [N+1];
  logic [RW-1:0]     rem [N+1];
  logic [AW-1:0]     acc [N+1];
  logic [SW-1:0]     den [N+1];
  logic [DIST_W-1:0] q   [N+1];

  psd_front #(
    .CW(COORD_WIDTH), .FRAC(FRAC_BITS), .SW(SW), .RW(RW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_valid), .in_data(in_data),
    .out_ctl(ctl[0]), .out_m(rem[0]), .out_den(den[0])
  );

  assign acc[0] = '0;
  assign q[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    psd_root_cell #(.BIT(N - 1 - i), .SW(SW), .RW(RW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_ctl(ctl[i]), .in_rem(rem[i]), .in_acc(acc[i]),
      .in_den(den[i]), .in_q(q[i]),
      .out_ctl(ctl[i+1]), .out_rem(rem[i+1]), .out_acc(acc[i+1]),
      .out_den(den[i+1]), .out_q(q[i+1])
    );
  end

  assign out_valid             = ctl[N].vld;
  assign out_data.distance     = q[N];
  assign out_data.nearest_part = ctl[N].part;

endmodule
